// File: hdl/spq_pkg.sv
// ----------------------------------------------------------------------------
// spq_pkg
// Types and constants shared by the strict priority event queue modules.
// ----------------------------------------------------------------------------
package spq_pkg;

   // Queue geometry.
   localparam int LEVELS       = 5;
   localparam int DEPTH        = 64;
   localparam int HANDLE_WIDTH = 32;

   // Field widths.
   localparam int LEVEL_WIDTH = 3;
   localparam int COUNT_WIDTH = $clog2(DEPTH + 1);
   localparam int ADDR_WIDTH  = $clog2(DEPTH);
   localparam int LIDX_WIDTH  = $clog2(LEVELS);

   // Depth of the queue between the front and the back.
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_WIDTH  = $clog2(QUEUE_DEPTH);
   localparam int QCNT_WIDTH  = $clog2(QUEUE_DEPTH + 1);

   // Operation codes.
   localparam logic OP_PUSH = 1'b0;
   localparam logic OP_POP  = 1'b1;

   // Input item as it arrives on the request channel.
   typedef struct packed {
      logic                    operation;
      logic [LEVEL_WIDTH-1:0]  level;
      logic [HANDLE_WIDTH-1:0] handle;
   } req_type;

   // Result item on the response channel.
   typedef struct packed {
      logic                    out_valid;
      logic [HANDLE_WIDTH-1:0] out_handle;
      logic [LEVEL_WIDTH-1:0]  out_level;
      logic                    overflow;
      logic [COUNT_WIDTH-1:0]  count;
   } rsp_type;

   // Classified item passed from the front to the back.
   typedef struct packed {
      logic                    is_pop;
      logic [LIDX_WIDTH-1:0]   level;
      logic [HANDLE_WIDTH-1:0] handle;
   } work_type;

endpackage

// File: hdl/spq_front.sv
// ----------------------------------------------------------------------------
// spq_front
// Accepts request items, decodes the operation and clamps the level to the
// last level, and holds the classified item in one register stage.
// ----------------------------------------------------------------------------
module spq_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  spq_pkg::req_type  req_payload,
   output logic              out_valid,
   input  logic              out_ready,
   output spq_pkg::work_type out_item
);
   import spq_pkg::*;

   logic     valid_ff;
   logic     valid_in;
   work_type item_ff;
   work_type item_in;
   logic     take;

   // The stage takes a new item when it is empty or being drained.
   assign req_ready = !valid_ff || out_ready;
   assign take      = req_valid && req_ready;

   // Classify: decode the operation and saturate the level.
   always_comb begin
      item_in.is_pop = (req_payload.operation == OP_POP);
      item_in.handle = req_payload.handle;
      if (req_payload.level >= LEVEL_WIDTH'(LEVELS)) begin
         item_in.level = LIDX_WIDTH'(LEVELS - 1);
      end else begin
         item_in.level = LIDX_WIDTH'(req_payload.level);
      end
   end

   // Valid flag of the stage.
   always_comb begin
      valid_in = valid_ff;
      if (take) begin
         valid_in = 1'b1;
      end else if (out_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         item_ff <= item_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_item  = item_ff;

endmodule

// File: hdl/spq_fifo.sv
// ----------------------------------------------------------------------------
// spq_fifo
// Short queue of classified items between the front and the back, so that
// each side can stall on its own.
// ----------------------------------------------------------------------------
module spq_fifo (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  spq_pkg::work_type in_item,
   output logic              out_valid,
   input  logic              out_ready,
   output spq_pkg::work_type out_item
);
   import spq_pkg::*;

   work_type              slots_ff [QUEUE_DEPTH];
   logic [QPTR_WIDTH-1:0] wr_ptr_ff;
   logic [QPTR_WIDTH-1:0] wr_ptr_in;
   logic [QPTR_WIDTH-1:0] rd_ptr_ff;
   logic [QPTR_WIDTH-1:0] rd_ptr_in;
   logic [QCNT_WIDTH-1:0] fill_ff;
   logic [QCNT_WIDTH-1:0] fill_in;
   logic                  push;
   logic                  pop;

   assign in_ready  = (fill_ff != QCNT_WIDTH'(QUEUE_DEPTH));
   assign out_valid = (fill_ff != '0);
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;
   assign out_item  = slots_ff[rd_ptr_ff];

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_WIDTH'(QUEUE_DEPTH - 1)) ? '0
                                                                  : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_WIDTH'(QUEUE_DEPTH - 1)) ? '0
                                                                  : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (pop && !push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // Item storage.
   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= in_item;
      end
   end

endmodule

// File: hdl/spq_back.sv
// ----------------------------------------------------------------------------
// spq_back
// Carries out pushes and pops on the linked lists in the shared store. The
// IDLE state reads the link and handle memories as it takes an item; the EXEC
// state writes back and loads the result register.
// ----------------------------------------------------------------------------
module spq_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  spq_pkg::work_type in_item,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output spq_pkg::rsp_type  rsp_payload
);
   import spq_pkg::*;

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_EXEC = 1'b1;

   // Shared store.
   logic [HANDLE_WIDTH-1:0] handle_mem [DEPTH];
   logic [ADDR_WIDTH-1:0]   link_mem   [DEPTH];
   logic [HANDLE_WIDTH-1:0] rd_handle_ff;
   logic [ADDR_WIDTH-1:0]   rd_link_ff;

   // List control state.
   logic [ADDR_WIDTH-1:0]  head_ff [LEVELS];
   logic [ADDR_WIDTH-1:0]  head_in [LEVELS];
   logic [ADDR_WIDTH-1:0]  tail_ff [LEVELS];
   logic [ADDR_WIDTH-1:0]  tail_in [LEVELS];
   logic [LEVELS-1:0]      nonempty_ff;
   logic [LEVELS-1:0]      nonempty_in;
   logic [ADDR_WIDTH-1:0]  free_head_ff;
   logic [ADDR_WIDTH-1:0]  free_head_in;
   logic [COUNT_WIDTH-1:0] never_used_ff;
   logic [COUNT_WIDTH-1:0] never_used_in;
   logic [COUNT_WIDTH-1:0] stored_ff;
   logic [COUNT_WIDTH-1:0] stored_in;

   // Sequencer and captured item.
   logic                  state_ff;
   logic                  state_in;
   work_type              item_ff;
   logic [LIDX_WIDTH-1:0] pop_lvl_ff;
   logic                  pop_any_ff;
   logic [ADDR_WIDTH-1:0] addr_ff;

   // Result register.
   logic    rsp_valid_ff;
   logic    rsp_valid_in;
   rsp_type rsp_ff;
   rsp_type rsp_in;

   // Memory access controls.
   logic                    rd_en;
   logic [ADDR_WIDTH-1:0]   rd_addr;
   logic                    handle_we;
   logic [ADDR_WIDTH-1:0]   handle_waddr;
   logic                    link_we;
   logic [ADDR_WIDTH-1:0]   link_waddr;
   logic [ADDR_WIDTH-1:0]   link_wdata;

   // Helpers.
   logic [LIDX_WIDTH-1:0] sel_lvl;
   logic                  sel_any;
   logic                  take;
   logic                  out_free;
   logic                  exec_fire;
   logic [ADDR_WIDTH-1:0] slot;

   assign in_ready  = (state_ff == ST_IDLE);
   assign take      = in_valid && in_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign exec_fire = (state_ff == ST_EXEC) && out_free;

   // Lowest-numbered level that is not empty.
   always_comb begin
      sel_lvl = '0;
      sel_any = 1'b0;
      for (int i = LEVELS - 1; i >= 0; i--) begin
         if (nonempty_ff[i]) begin
            sel_lvl = LIDX_WIDTH'(i);
            sel_any = 1'b1;
         end
      end
   end

   // Read address: head of the served level for a pop, free list head for a push.
   assign rd_en   = take;
   assign rd_addr = in_item.is_pop ? head_ff[sel_lvl] : free_head_ff;

   // Entry a push takes: a never used one first, then the free list head.
   assign slot = (never_used_ff < COUNT_WIDTH'(DEPTH)) ? never_used_ff[ADDR_WIDTH-1:0]
                                                       : addr_ff;

   // Sequencer.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (take) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // List update and result of the EXEC state.
   always_comb begin
      head_in       = head_ff;
      tail_in       = tail_ff;
      nonempty_in   = nonempty_ff;
      free_head_in  = free_head_ff;
      never_used_in = never_used_ff;
      stored_in     = stored_ff;
      handle_we     = 1'b0;
      handle_waddr  = slot;
      link_we       = 1'b0;
      link_waddr    = tail_ff[item_ff.level];
      link_wdata    = slot;
      rsp_in        = '0;
      if (exec_fire) begin
         if (!item_ff.is_pop) begin
            if (stored_ff >= COUNT_WIDTH'(DEPTH)) begin
               // Full store: the push is dropped.
               rsp_in.overflow = 1'b1;
            end else begin
               if (never_used_ff < COUNT_WIDTH'(DEPTH)) begin
                  never_used_in = never_used_ff + COUNT_WIDTH'(1);
               end else begin
                  free_head_in = rd_link_ff;
               end
               handle_we = 1'b1;
               if (nonempty_ff[item_ff.level]) begin
                  link_we = 1'b1;
               end else begin
                  head_in[item_ff.level]     = slot;
                  nonempty_in[item_ff.level] = 1'b1;
               end
               tail_in[item_ff.level] = slot;
               stored_in              = stored_ff + COUNT_WIDTH'(1);
            end
         end else if (pop_any_ff) begin
            // Pop the head entry and put it at the head of the free list.
            if (addr_ff == tail_ff[pop_lvl_ff]) begin
               nonempty_in[pop_lvl_ff] = 1'b0;
            end else begin
               head_in[pop_lvl_ff] = rd_link_ff;
            end
            link_we      = 1'b1;
            link_waddr   = addr_ff;
            link_wdata   = free_head_ff;
            free_head_in = addr_ff;
            if (stored_ff != '0) begin
               stored_in = stored_ff - COUNT_WIDTH'(1);
            end
            rsp_in.out_valid  = 1'b1;
            rsp_in.out_handle = rd_handle_ff;
            rsp_in.out_level  = LEVEL_WIDTH'(pop_lvl_ff);
         end
         rsp_in.count = stored_in;
      end
   end

   // Result register valid flag.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (exec_fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rsp_valid_ff  <= 1'b0;
         nonempty_ff   <= '0;
         free_head_ff  <= '0;
         never_used_ff <= '0;
         stored_ff     <= '0;
         for (int i = 0; i < LEVELS; i++) begin
            head_ff[i] <= '0;
            tail_ff[i] <= '0;
         end
      end else begin
         state_ff      <= state_in;
         rsp_valid_ff  <= rsp_valid_in;
         nonempty_ff   <= nonempty_in;
         free_head_ff  <= free_head_in;
         never_used_ff <= never_used_in;
         stored_ff     <= stored_in;
         head_ff       <= head_in;
         tail_ff       <= tail_in;
      end
   end

   // Captured item and pop decision.
   always_ff @(posedge clock) begin
      if (take) begin
         item_ff    <= in_item;
         pop_lvl_ff <= sel_lvl;
         pop_any_ff <= sel_any;
         addr_ff    <= rd_addr;
      end
      if (exec_fire) begin
         rsp_ff <= rsp_in;
      end
   end

   // Handle memory.
   always_ff @(posedge clock) begin
      if (handle_we) begin
         handle_mem[handle_waddr] <= item_ff.handle;
      end
      if (rd_en) begin
         rd_handle_ff <= handle_mem[rd_addr];
      end
   end

   // Link memory.
   always_ff @(posedge clock) begin
      if (link_we) begin
         link_mem[link_waddr] <= link_wdata;
      end
      if (rd_en) begin
         rd_link_ff <= link_mem[rd_addr];
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

// File: hdl/strict_priority_event_queue.sv
// ----------------------------------------------------------------------------
// strict_priority_event_queue
// Event queue with strict priority levels sharing one linked store.
//
//   Channel   Ports                             Direction
//   request   req_valid, req_ready, req_payload in  (push or pop item)
//   response  rsp_valid, rsp_ready, rsp_payload out (one result per item)
//
// In the back end each item reads the link and handle memories as it is
// taken, then writes them back and loads the result register in EXEC.
// A front register and a two-entry queue keep taking items while the back
// end works or a result waits. Reset clears the control state only;
// the memories need no clearing pass. A stalled response holds the back
// end in its write-back cycle until the result register frees.
// ----------------------------------------------------------------------------
module strict_priority_event_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  spq_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output spq_pkg::rsp_type rsp_payload
);
   import spq_pkg::*;

   logic     front_valid;
   logic     front_ready;
   work_type front_item;
   logic     queue_valid;
   logic     queue_ready;
   work_type queue_item;

   // Front: accept and classify.
   spq_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .out_valid   (front_valid),
      .out_ready   (front_ready),
      .out_item    (front_item)
   );

   // Queue between front and back.
   spq_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (front_valid),
      .in_ready  (front_ready),
      .in_item   (front_item),
      .out_valid (queue_valid),
      .out_ready (queue_ready),
      .out_item  (queue_item)
   );

   // Back: list operations and result.
   spq_back u_back (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (queue_valid),
      .in_ready    (queue_ready),
      .in_item     (queue_item),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule
